// ----- sv/assert_macros.svh -----
// Assertion macros shared by the sorted-set RTL.
// No dependencies; files that check their logic include this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SSTI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define SSTI_NEVER(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error(msg);
`else
`define SSTI_ASSERT(lbl, clk, rstn, prop, msg)
`define SSTI_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ----- sv/ssti_pkg.sv -----
// Types and constants for the sorted-set toggle core.
// No dependencies; used by ssti_cell and sorted_set_toggle_insert_core.
package ssti_pkg;

  localparam int DATA_W    = 32;
  localparam int ACTION_W  = 2;
  localparam int POS_OUT_W = 6;
  localparam int CNT_OUT_W = 7;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERTED = 2'd0,
    ACT_REMOVED  = 2'd1,
    ACT_REJECTED = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp;   // compare held word against the entry, latch flags
    logic ins;   // open a slot at the boundary and load the word
    logic rem;   // close the slot of the matching entry
  } cell_ctl_t;

endpackage

// ----- sv/ssti_cell.sv -----
// One slot of the sorted table: entry register plus compare flags.
// Depends on ssti_pkg; instantiated in a row by sorted_set_toggle_insert_core.
module ssti_cell #(
  parameter int CNT_W = 7,
  parameter int IDX   = 0
) (
  input  logic                             clk,
  input  ssti_pkg::cell_ctl_t              ctl,
  input  logic signed [ssti_pkg::DATA_W-1:0] value,
  input  logic [CNT_W-1:0]                 count,
  input  logic [ssti_pkg::DATA_W-1:0]      left_entry,
  input  logic                             left_lt,
  input  logic [ssti_pkg::DATA_W-1:0]      right_entry,
  output logic [ssti_pkg::DATA_W-1:0]      entry,
  output logic                             lt,
  output logic                             eq
);

  logic [ssti_pkg::DATA_W-1:0] entry_r;
  logic                        lt_r;
  logic                        eq_r;
  logic                        valid;

  assign valid = count > CNT_W'(IDX);

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      lt_r <= valid && ($signed(entry_r) < value);
      eq_r <= valid && (entry_r == value);
    end
  end

  // slots at or past the boundary move; on insert the boundary slot takes the new word
  always_ff @(posedge clk) begin
    if (ctl.ins && !lt_r) begin
      entry_r <= left_lt ? value : left_entry;
    end else if (ctl.rem && !lt_r) begin
      entry_r <= right_entry;
    end
  end

  assign entry = entry_r;
  assign lt    = lt_r;
  assign eq    = eq_r;

endmodule

// ----- sv/sorted_set_toggle_insert_core.sv -----
// Sorted-set toggle core: top level with control FSM and a row of ssti_cell slots.
// Depends on ssti_pkg, ssti_cell and assert_macros.svh.
//
// Keeps up to CAPACITY distinct signed 32-bit words in ascending order. Each
// input word toggles membership: a stored word is removed and later entries
// slide down one slot; an absent word is inserted at its sorted slot and later
// entries slide up. A full table rejects an absent word (action 2, position 0,
// table unchanged). Each result word carries action, position and the count
// after the step. Each item passes through accept, a compare state in which
// every cell checks the held word against its entry at once, and an update
// state in which the cells shift and the result is registered. The update
// waits while the previous result still sits unread in the output register.
// The table entries have no reset; the count, state and output valid are cleared.
`include "assert_macros.svh"

module sorted_set_toggle_insert_core #(
  parameter int CAPACITY = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [ssti_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [ssti_pkg::ACTION_W-1:0]      out_action,
  output logic [ssti_pkg::POS_OUT_W-1:0]     out_position,
  output logic [ssti_pkg::CNT_OUT_W-1:0]     out_entry_count
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  // wide enough for both the internal count and the output fields
  localparam int POS_X_W = (CNT_W > ssti_pkg::CNT_OUT_W) ? CNT_W : ssti_pkg::CNT_OUT_W;

  ssti_pkg::state_t    state_r, state_nxt;
  ssti_pkg::cell_ctl_t ctl;

  logic signed [ssti_pkg::DATA_W-1:0] value_r;
  logic [CNT_W-1:0]                   count_r, count_nxt;

  logic                          out_valid_r;
  ssti_pkg::action_t             action_r;
  logic [ssti_pkg::POS_OUT_W-1:0] position_r;
  logic [ssti_pkg::CNT_OUT_W-1:0] entry_count_r;

  logic [ssti_pkg::DATA_W-1:0] entry_w [CAPACITY];
  logic [CAPACITY-1:0]         lt_w;
  logic [CAPACITY-1:0]         eq_w;
  logic [CAPACITY-1:0]         bnd_w;   // first slot not below the word
  logic [CNT_W-1:0]            pos;
  logic                        hit;
  logic                        full;
  logic                        go;
  ssti_pkg::action_t           action_nxt;
  logic [POS_X_W-1:0]          pos_x;
  logic [POS_X_W-1:0]          cnt_x;

  // ---------------------------------------------------------------- cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ssti_pkg::DATA_W-1:0] left_e;
    logic [ssti_pkg::DATA_W-1:0] right_e;
    logic                        left_l;
    if (i == 0) begin : g_first
      assign left_e = entry_w[0];
      assign left_l = 1'b1;
    end else begin : g_mid
      assign left_e = entry_w[i-1];
      assign left_l = lt_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_e = entry_w[i];
    end else begin : g_inner
      assign right_e = entry_w[i+1];
    end

    ssti_cell #(
      .CNT_W (CNT_W),
      .IDX   (i)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .value       (value_r),
      .count       (count_r),
      .left_entry  (left_e),
      .left_lt     (left_l),
      .right_entry (right_e),
      .entry       (entry_w[i]),
      .lt          (lt_w[i]),
      .eq          (eq_w[i])
    );

    // lt flags form a thermometer over the sorted valid slots
    assign bnd_w[i] = left_l && !lt_w[i];
  end

  // boundary index: OR of the one slot index that is flagged
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (bnd_w[i]) begin
        pos = pos | CNT_W'(i);
      end
    end
  end

  assign hit  = |eq_w;
  assign full = count_r == CNT_W'(CAPACITY);
  assign go   = !out_valid_r || out_ready;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ssti_pkg::S_IDLE: if (in_valid) state_nxt = ssti_pkg::S_CMP;
      ssti_pkg::S_CMP:  state_nxt = ssti_pkg::S_UPD;
      ssti_pkg::S_UPD:  if (go) state_nxt = ssti_pkg::S_IDLE;
      default:          state_nxt = ssti_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    ctl      = '0;
    unique case (state_r)
      ssti_pkg::S_IDLE: in_ready = 1'b1;
      ssti_pkg::S_CMP:  ctl.cmp = 1'b1;
      ssti_pkg::S_UPD: begin
        ctl.rem = go && hit;
        ctl.ins = go && !hit && !full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssti_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      value_r <= in_value;
    end
  end

  // ---------------------------------------------------------------- count/result
  always_comb begin
    count_nxt = count_r;
    if (ctl.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end else if (ctl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_comb begin
    priority if (hit) begin
      action_nxt = ssti_pkg::ACT_REMOVED;
    end else if (full) begin
      action_nxt = ssti_pkg::ACT_REJECTED;
    end else begin
      action_nxt = ssti_pkg::ACT_INSERTED;
    end
  end

  assign pos_x = (!hit && full) ? '0 : POS_X_W'(pos);
  assign cnt_x = POS_X_W'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (state_r == ssti_pkg::S_UPD && go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ssti_pkg::S_UPD && go) begin
      action_r      <= action_nxt;
      position_r    <= pos_x[ssti_pkg::POS_OUT_W-1:0];
      entry_count_r <= cnt_x[ssti_pkg::CNT_OUT_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_action      = action_r;
  assign out_position    = position_r;
  assign out_entry_count = entry_count_r;

  // ---------------------------------------------------------------- checks
  `SSTI_NEVER(a_count_bound, clk, rst_n, count_r > CNT_W'(CAPACITY), "count past capacity")
  `SSTI_ASSERT(a_one_bnd, clk, rst_n, (state_r == ssti_pkg::S_UPD) |-> $onehot0(bnd_w), "lt flags not a thermometer")
  `SSTI_ASSERT(a_one_hit, clk, rst_n, (state_r == ssti_pkg::S_UPD) |-> $onehot0(eq_w), "duplicate entry in table")
  `SSTI_ASSERT(a_accept_cmp, clk, rst_n, (in_valid && in_ready) |=> (state_r == ssti_pkg::S_CMP), "accept not followed by compare")
  `SSTI_NEVER(a_ins_rem, clk, rst_n, ctl.ins && ctl.rem, "insert and remove together")

endmodule
